FILE: rtl/core/bmmd_pkg.sv
// ----------------------------------------------------------------------------
// bmmd_pkg
// Shared types, codes and constants of the banked memory map decoder.
// ----------------------------------------------------------------------------
package bmmd_pkg;

	// RAM is a power-of-two store; the address width sets its depth.
	localparam int RAM_AW    = 16;
	localparam int RAM_DEPTH = 1 << RAM_AW;
	localparam int IO_AW     = 10;
	localparam int IO_DEPTH  = 576;
	localparam int ROM_AW    = 14;
	localparam int PADDR_W   = 3;

	localparam logic [15:0] ADDR_FIXED_FF = 16'hFF08;
	localparam logic [15:0] ADDR_ROM_ON   = 16'hFF3E;
	localparam logic [15:0] ADDR_ROM_OFF  = 16'hFF3F;
	localparam logic [15:0] IO_BASE       = 16'hFD00;
	localparam logic [15:0] IO_LAST_ADDR  = 16'(32'hFD00 + IO_DEPTH - 1);
	localparam logic [11:0] CFG_PAGE      = 12'hFDD;
	localparam logic [15:0] BASIC_BASE    = 16'h8000;
	localparam logic [15:0] KERNAL_BASE   = 16'hC000;
	localparam logic [7:0]  LOW_KERNAL_PG = 8'hFC;
	localparam logic [7:0]  FIXED_BYTE    = 8'hFF;
	localparam logic [IO_AW-1:0]  IO_LAST  = IO_AW'(IO_DEPTH - 1);
	localparam logic [RAM_AW-1:0] RAM_LAST = RAM_AW'(RAM_DEPTH - 1);

	localparam logic [1:0] RAM_SIZE_RESET = 2'd2;

	// Register index within the configuration space (paddr[2]).
	localparam logic REG_RAM_SIZE = 1'b0;

	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		SRC_RAM    = 3'd0,
		SRC_IO     = 3'd1,
		SRC_BASIC  = 3'd2,
		SRC_KERNAL = 3'd3,
		SRC_FIXED  = 3'd4
	} src_t;

	// Where the returned byte comes from once the memories have answered.
	typedef enum logic [1:0] {
		RSEL_ZERO = 2'd0,
		RSEL_RAM  = 2'd1,
		RSEL_IO   = 2'd2,
		RSEL_FF   = 2'd3
	} rsel_t;

	typedef enum logic {
		MODE_CLEAR = 1'b0,
		MODE_RUN   = 1'b1
	} mode_t;

	typedef struct packed {
		src_t              src;
		rsel_t             rsel;
		logic [ROM_AW-1:0] offs;
		logic              rom_on;
		logic [3:0]        rom_sel;
	} decode_t;

	// Wrap a bus address to the installed RAM size; codes above 2 act as 64K.
	function automatic logic [RAM_AW-1:0] ram_index(input logic [15:0] addr,
			input logic [1:0] size_sel);
		logic [15:0] mask;
		begin
			unique case (size_sel)
				2'd0:    mask = 16'h3FFF;
				2'd1:    mask = 16'h7FFF;
				default: mask = 16'hFFFF;
			endcase
			ram_index = RAM_AW'(addr & mask);
		end
	endfunction

endpackage

FILE: rtl/core/banked_memory_map_decoder_top.sv
// ----------------------------------------------------------------------------
// banked_memory_map_decoder_top
// Decodes one bus access per transaction through a banked map of RAM, an I/O
// register store and two external ROMs.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every RAM entry that
// zeroes RAM and the I/O store; in_stall stays high throughout, while
// configuration writes are taken as usual. From then on it takes one access
// every clock: the access reads or writes the single-port RAM or I/O memory
// at the accepting edge, the registered read data is merged in the next
// cycle and the result sits in an output register, so one transaction a
// cycle is sustained as long as out_stall stays low. The ROM banking state
// updates at the accepting edge, so a following access sees it at once; a
// read right after a write to the same location also sees the new byte,
// since the write lands at its own accepting edge, before the read.
module banked_memory_map_decoder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// access channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [15:0]                   address,
	input  logic [7:0]                    write_data,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    read_data,
	output logic [2:0]                    data_source,
	output logic [13:0]                   rom_offset,
	output logic                          rom_on,
	output logic [3:0]                    rom_select,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bmmd_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import bmmd_pkg::*;

	// Memories: RAM and the I/O register store, one port each.
	logic [7:0] ram_mem [RAM_DEPTH];
	logic [7:0] io_mem  [IO_DEPTH];

	mode_t             mode_q, mode_d;
	logic [RAM_AW-1:0] clr_idx_q;
	logic              clearing;

	logic [1:0] ram_size_q;
	logic       rom_on_q;
	logic [3:0] rom_sel_q;

	logic      s1_valid_q;
	decode_t   dec_s1;
	logic [7:0] ram_rd_s1;
	logic [7:0] io_rd_s1;

	logic       out_valid_q;
	decode_t    out_dec_q;
	logic [7:0] out_data_q;

	logic in_accept, s1_move, cfg_write;
	logic in_io, in_cfg;
	logic [IO_AW-1:0]  io_idx;
	logic [RAM_AW-1:0] ram_idx;
	decode_t dec_d;
	logic    next_rom_on;
	logic [3:0] next_rom_sel;

	logic              ram_we, ram_re, io_we, io_re;
	logic [RAM_AW-1:0] ram_addr;
	logic [IO_AW-1:0]  io_addr;
	logic [7:0]        ram_wd, io_wd;
	logic [7:0]        merged_data;

	// ---- configuration port ------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[2] == REG_RAM_SIZE) ? {30'd0, ram_size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_size_q <= RAM_SIZE_RESET;
		end else if (cfg_write && paddr[2] == REG_RAM_SIZE) begin
			ram_size_q <= pwdata[1:0];
		end
	end

	// ---- clearing pass sequencer -------------------------------------------
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_CLEAR: if (clr_idx_q == RAM_LAST) mode_d = MODE_RUN;
			MODE_RUN:   mode_d = MODE_RUN;
			default:    mode_d = MODE_CLEAR;
		endcase
	end

	always_comb begin
		clearing = (mode_q == MODE_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_CLEAR;
			clr_idx_q <= '0;
		end else begin
			mode_q <= mode_d;
			if (clearing) clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// ---- handshake ---------------------------------------------------------
	// Advance stage 1 into the output register whenever that register is free.
	assign s1_move   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall  = clearing || (s1_valid_q && !s1_move);
	assign in_accept = in_valid && !in_stall;

	// ---- address decode ----------------------------------------------------
	assign in_io   = (address >= IO_BASE) && (address <= IO_LAST_ADDR);
	assign in_cfg  = (address[15:4] == CFG_PAGE);
	assign io_idx  = IO_AW'(address - IO_BASE);
	assign ram_idx = ram_index(address, ram_size_q);

	always_comb begin
		next_rom_on  = rom_on_q;
		next_rom_sel = rom_sel_q;
		dec_d.src    = SRC_RAM;
		dec_d.rsel   = RSEL_ZERO;
		dec_d.offs   = '0;
		if (cmd == CMD_WRITE) begin
			priority if (address == ADDR_ROM_ON) begin
				next_rom_on = 1'b1;
			end else if (address == ADDR_ROM_OFF) begin
				next_rom_on = 1'b0;
			end else if (in_cfg) begin
				next_rom_sel = address[3:0];
			end else begin
				// plain store: hold the banking state
				next_rom_on = rom_on_q;
			end
		end else begin
			priority if (address == ADDR_FIXED_FF) begin
				dec_d.src  = SRC_FIXED;
				dec_d.rsel = RSEL_FF;
			end else if (in_io) begin
				dec_d.src  = SRC_IO;
				dec_d.rsel = RSEL_IO;
			end else if (!rom_on_q || address < BASIC_BASE) begin
				dec_d.src  = SRC_RAM;
				dec_d.rsel = RSEL_RAM;
			end else if (rom_sel_q[1:0] == 2'b00 && address < KERNAL_BASE) begin
				dec_d.src  = SRC_BASIC;
				dec_d.offs = address[ROM_AW-1:0];
			end else if ((rom_sel_q[3:2] == 2'b00 && address >= KERNAL_BASE) ||
					address[15:8] == LOW_KERNAL_PG) begin
				// the low kernal window ignores the high config bits
				dec_d.src  = SRC_KERNAL;
				dec_d.offs = address[ROM_AW-1:0];
			end else begin
				// absent ROM
				dec_d.src  = SRC_FIXED;
				dec_d.rsel = RSEL_FF;
			end
		end
		dec_d.rom_on  = next_rom_on;
		dec_d.rom_sel = next_rom_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_on_q  <= 1'b1;
			rom_sel_q <= 4'd0;
		end else if (in_accept) begin
			rom_on_q  <= next_rom_on;
			rom_sel_q <= next_rom_sel;
		end
	end

	// ---- memory ports ------------------------------------------------------
	// Route the write ports to the sweep during the clearing pass.
	always_comb begin
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		io_we    = 1'b0;
		io_re    = 1'b0;
		ram_addr = ram_idx;
		io_addr  = io_idx;
		ram_wd   = write_data;
		io_wd    = write_data;
		if (clearing) begin
			ram_we   = 1'b1;
			ram_addr = clr_idx_q;
			ram_wd   = 8'd0;
			io_we    = (clr_idx_q[IO_AW-1:0] <= IO_LAST);
			io_addr  = clr_idx_q[IO_AW-1:0];
			io_wd    = 8'd0;
		end else if (in_accept) begin
			if (cmd == CMD_WRITE) begin
				io_we  = in_io && !in_cfg && address != ADDR_ROM_ON &&
						address != ADDR_ROM_OFF;
				ram_we = !in_io;
			end else begin
				io_re  = (dec_d.rsel == RSEL_IO);
				ram_re = (dec_d.rsel == RSEL_RAM);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) ram_mem[ram_addr] <= ram_wd;
		if (ram_re) ram_rd_s1 <= ram_mem[ram_addr];
	end

	always_ff @(posedge clk) begin
		if (io_we) io_mem[io_addr] <= io_wd;
		if (io_re) io_rd_s1 <= io_mem[io_addr];
	end

	// ---- stage 1 and output register ---------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) dec_s1 <= dec_d;
	end

	always_comb begin
		unique case (dec_s1.rsel)
			RSEL_RAM: merged_data = ram_rd_s1;
			RSEL_IO:  merged_data = io_rd_s1;
			RSEL_FF:  merged_data = FIXED_BYTE;
			default:  merged_data = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_dec_q  <= dec_s1;
			out_data_q <= merged_data;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = out_data_q;
	assign data_source = out_dec_q.src;
	assign rom_offset  = out_dec_q.offs;
	assign rom_on      = out_dec_q.rom_on;
	assign rom_select  = out_dec_q.rom_sel;

	// ---- assertions --------------------------------------------------------
`ifndef NO_ASSERTIONS
	// Hold off accesses until the clearing pass is done.
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_accept)
		else $error("access taken during clearing pass");

	// Stage 1 must never be overwritten while its result is still held.
	a_s1_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_move) |-> !in_accept)
		else $error("stage 1 overwritten");

	// The clearing pass ends only after the sweep reached the last entry.
	a_clear_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mode_q == MODE_RUN) |-> $past(clr_idx_q) == RAM_LAST)
		else $error("clearing pass ended early");
`endif

endmodule

FILE: tb/bank_map_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_map_checker
// Watches the access, result and configuration channels of the banked memory
// map decoder, predicts each result from a shadow of the memory map and
// compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module bank_map_checker
	import bmmd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                cmd,
	input  logic [15:0]         address,
	input  logic [7:0]          write_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [7:0]          read_data,
	input  logic [2:0]          data_source,
	input  logic [13:0]         rom_offset,
	input  logic                rom_on,
	input  logic [3:0]          rom_select,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output int                  mismatches,
	output int                  pending
);

	typedef struct packed {
		logic [7:0]  rdata;
		src_t        src;
		logic [13:0] offs;
		logic        visible;
		logic [3:0]  bank_cfg;
	} bank_result_t;

	logic [7:0]   ram_shadow [0:RAM_DEPTH-1];
	logic [7:0]   io_shadow [0:IO_DEPTH-1];
	logic         rom_visible;
	logic [3:0]   rom_bank_cfg;
	logic [1:0]   ram_size_sel;
	bank_result_t predicted_decodes [$];

	// Fold an address onto the installed RAM; size codes 2 and 3 keep all bits.
	function automatic logic [15:0] wrap_to_ram(input logic [15:0] a);
		logic [15:0] keep;
		begin
			keep = ~(16'hFFFF << (14 + ram_size_sel));
			return a & keep;
		end
	endfunction

	function automatic bank_result_t decode_access(input cmd_t c, input logic [15:0] a,
			input logic [7:0] d);
		bank_result_t r;
		logic         io_hit;
		begin
			r = '0;
			r.src = SRC_RAM;
			io_hit = (a >= IO_BASE) && (a <= IO_LAST_ADDR);
			if (c == CMD_WRITE) begin
				if (a == ADDR_ROM_ON)
					rom_visible = 1'b1;
				else if (a == ADDR_ROM_OFF)
					rom_visible = 1'b0;
				else if (a[15:4] == CFG_PAGE)
					rom_bank_cfg = a[3:0];
				else if (io_hit)
					io_shadow[IO_AW'(a - IO_BASE)] = d;
				else
					ram_shadow[wrap_to_ram(a)] = d;
			end else if (a == ADDR_FIXED_FF) begin
				r.rdata = FIXED_BYTE;
				r.src   = SRC_FIXED;
			end else if (io_hit) begin
				r.rdata = io_shadow[IO_AW'(a - IO_BASE)];
				r.src   = SRC_IO;
			end else if (!rom_visible || a < BASIC_BASE) begin
				r.rdata = ram_shadow[wrap_to_ram(a)];
			end else if (rom_bank_cfg[1:0] == 2'b00 && a < KERNAL_BASE) begin
				r.src  = SRC_BASIC;
				r.offs = a[13:0];
			end else if ((rom_bank_cfg[3:2] == 2'b00 && a >= KERNAL_BASE) ||
					a[15:8] == LOW_KERNAL_PG) begin
				// the low kernal page stays mapped whatever the high bits say
				r.src  = SRC_KERNAL;
				r.offs = a[13:0];
			end else begin
				r.rdata = FIXED_BYTE;
				r.src   = SRC_FIXED;
			end
			r.visible  = rom_visible;
			r.bank_cfg = rom_bank_cfg;
			return r;
		end
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bank_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < RAM_DEPTH; i++)
				ram_shadow[i] = 8'h00;
			for (int i = 0; i < IO_DEPTH; i++)
				io_shadow[i] = 8'h00;
			rom_visible  = 1'b1;
			rom_bank_cfg = 4'h0;
			ram_size_sel = RAM_SIZE_RESET;
			predicted_decodes.delete();
			mismatches   = 0;
			pending     <= 0;
		end else begin
			// retire first so that a result never matches its own access
			if (out_valid && !out_stall) begin
				if (predicted_decodes.size() == 0) begin
					mismatches++;
					$display("%0t ns: result with no access outstanding, expected none, got %0h",
						$time, read_data);
				end else begin
					want = predicted_decodes.pop_front();
					compare_field("read_data", want.rdata, read_data);
					compare_field("data_source", want.src, data_source);
					compare_field("rom_offset", want.offs, rom_offset);
					compare_field("rom_on", want.visible, rom_on);
					compare_field("rom_select", want.bank_cfg, rom_select);
				end
			end
			if (in_valid && !in_stall)
				predicted_decodes.push_back(decode_access(cmd_t'(cmd), address, write_data));
			if (psel && penable && pwrite && pready && paddr == {REG_RAM_SIZE, 2'b00})
				ram_size_sel = pwdata[1:0];
			pending <= predicted_decodes.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bus accesses and RAM size settings into the banked memory map
// decoder, with bursty access traffic and a patterned result stall, and
// reports whether the checker saw any mismatch.
// ----------------------------------------------------------------------------
module testbench;
	import bmmd_pkg::*;

	// The clearing pass alone keeps the access channel shut for a whole RAM
	// sweep, so the watchdog limit is a multiple of RAM_DEPTH.
	localparam int WATCHDOG_LIMIT = 4 * RAM_DEPTH;
	localparam int ITEMS_PER_PHASE = 265;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                cmd;
	logic [15:0]         address;
	logic [7:0]          write_data;
	logic                out_valid;
	logic                out_stall;
	logic [7:0]          read_data;
	logic [2:0]          data_source;
	logic [13:0]         rom_offset;
	logic                rom_on;
	logic [3:0]          rom_select;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	int                  mismatches;
	int                  pending;
	int                  burst_left;
	int                  idle_cycles;
	int                  stall_left;
	int                  stall_mode;
	int unsigned         cyc;
	logic [15:0]         written_ram [0:15];
	int                  written_ptr;
	logic [1:0]          size_plan [0:6] = '{2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd2};

	banked_memory_map_decoder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.address     (address),
		.write_data  (write_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.data_source (data_source),
		.rom_offset  (rom_offset),
		.rom_on      (rom_on),
		.rom_select  (rom_select),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	bank_map_checker map_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.address     (address),
		.write_data  (write_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.data_source (data_source),
		.rom_offset  (rom_offset),
		.rom_on      (rom_on),
		.rom_select  (rom_select),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	always #6 clk = ~clk;

	// Result stall: switch at random between four patterns, one of them
	// never stalling at all.
	always @(posedge clk) begin
		if (arst_n) begin
			cyc <= cyc + 1;
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_left <= $urandom_range(20, 200);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				0: begin
					out_stall <= 1'b0;
				end
				1: begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
				2: begin
					out_stall <= 1'($urandom_range(0, 1));
				end
				default: begin
					// long periodic stall, held for most of each period
					out_stall <= (cyc[4:0] < 5'd20);
				end
			endcase
		end
	end

	// Watchdog: end the run once nothing has moved on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(psel && penable && pready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Offer one transaction and hold it until the block takes it. A burst
	// that has run out is followed by a random gap; a zero gap keeps valid
	// high so that back-to-back transactions are exercised too.
	task automatic send_access(input cmd_t acc_cmd, input logic [15:0] acc_addr,
			input logic [7:0] acc_data);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
		end
		in_valid   <= 1'b1;
		cmd        <= acc_cmd;
		address    <= acc_addr;
		write_data <= acc_data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
	endtask

	// Draw one access, weighted towards the interesting corners of the map.
	task automatic send_random_access();
		logic [15:0] a;
		logic [7:0]  d;
		cmd_t        c;
		int          pick;
		d    = 8'($urandom);
		c    = cmd_t'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			// revisit a recently written RAM byte, often through a wrapped alias
			a = written_ram[$urandom_range(0, 15)] ^ {2'($urandom_range(0, 3)), 14'd0};
		end else if (pick < 40) begin
			a = 16'($urandom_range(0, 16'h7FFF));
		end else if (pick < 55) begin
			a = IO_BASE + 16'($urandom_range(0, IO_DEPTH - 1));
		end else if (pick < 62) begin
			a = {CFG_PAGE, 4'($urandom)};
			c = ($urandom_range(0, 4) == 0) ? CMD_READ : CMD_WRITE;
		end else if (pick < 68) begin
			a = $urandom_range(0, 1) ? ADDR_ROM_ON : ADDR_ROM_OFF;
			c = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_WRITE;
		end else if (pick < 72) begin
			a = ADDR_FIXED_FF;
		end else if (pick < 78) begin
			a = {LOW_KERNAL_PG, 8'($urandom)};
		end else if (pick < 90) begin
			a = 16'($urandom_range(16'h8000, 16'hFFFF));
		end else begin
			a = 16'($urandom);
		end
		if (c == CMD_WRITE && (a < IO_BASE || a > IO_LAST_ADDR)) begin
			written_ram[written_ptr] = a;
			written_ptr = (written_ptr + 1) % 16;
		end
		send_access(c, a, d);
	endtask

	// Drop valid and wait until every predicted result has come back, then
	// let the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// Write the RAM size register in two steps: setup, then access.
	task automatic set_ram_size(input logic [1:0] code);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_RAM_SIZE, 2'b00};
		pwdata  <= {30'd0, code};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		cmd         = CMD_READ;
		address     = 16'h0000;
		write_data  = 8'h00;
		out_stall   = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = 32'd0;
		burst_left  = 0;
		idle_cycles = 0;
		stall_left  = 0;
		stall_mode  = 0;
		cyc         = 0;
		written_ptr = 0;
		for (int i = 0; i < 16; i++)
			written_ram[i] = 16'($urandom_range(0, 16'h7FFF));

		// Hold reset low, then release it once.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Write the size register while the clearing pass is still running.
		set_ram_size(RAM_SIZE_RESET);

		// Directed accesses: fixed FF, the I/O store at both ends, both ROMs
		// at both ends, RAM under ROM, bank switching and the low kernal page.
		send_access(CMD_READ,  ADDR_FIXED_FF, 8'h00);
		send_access(CMD_WRITE, ADDR_FIXED_FF, 8'hA5);
		send_access(CMD_READ,  ADDR_FIXED_FF, 8'h00);
		send_access(CMD_READ,  16'hFD00, 8'h00);
		send_access(CMD_WRITE, 16'hFD00, 8'h5A);
		send_access(CMD_READ,  16'hFD00, 8'hFF);
		send_access(CMD_WRITE, 16'hFF3D, 8'hC3);
		send_access(CMD_READ,  16'hFF3D, 8'h00);
		send_access(CMD_READ,  ADDR_ROM_ON, 8'h00);
		send_access(CMD_READ,  16'h8000, 8'h00);
		send_access(CMD_READ,  16'hBFFF, 8'h00);
		send_access(CMD_READ,  16'hC000, 8'h00);
		send_access(CMD_READ,  16'hFFFF, 8'h00);
		send_access(CMD_WRITE, 16'h0000, 8'hFF);
		send_access(CMD_READ,  16'h0000, 8'h00);
		send_access(CMD_WRITE, 16'hFFFF, 8'h81);
		send_access(CMD_WRITE, 16'hFDDF, 8'h77);
		send_access(CMD_READ,  16'h8000, 8'h00);
		send_access(CMD_READ,  16'hFC00, 8'h00);
		send_access(CMD_READ,  16'hFCFF, 8'h00);
		send_access(CMD_WRITE, ADDR_ROM_OFF, 8'h00);
		send_access(CMD_READ,  16'hFFFF, 8'h00);
		send_access(CMD_WRITE, ADDR_ROM_ON, 8'hFF);
		send_access(CMD_WRITE, 16'hFDD0, 8'hFF);
		send_access(CMD_READ,  16'h7FFF, 8'h00);

		// Random phases, each under its own RAM size; change the size only
		// with the block idle, and keep RAM contents across the change.
		foreach (size_plan[p]) begin
			drain();
			set_ram_size(size_plan[p]);
			repeat (ITEMS_PER_PHASE) send_random_access();
		end

		drain();
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
